// File: src/iac_pkg.sv
// Package for the intrusion alarm controller: alarm state encoding, key codes,
// field widths and register reset values. No dependencies.
`default_nettype none

package iac_pkg;

  typedef enum logic [2:0] {
    ST_OFF    = 3'd0,
    ST_EXIT   = 3'd1,
    ST_ARMED  = 3'd2,
    ST_DETECT = 3'd3,
    ST_ENTRY  = 3'd4,
    ST_SIREN  = 3'd5
  } alarm_state_t;

  typedef enum logic [2:0] {
    REG_CODE_DIGITS  = 3'd0,
    REG_CODE_LENGTH  = 3'd1,
    REG_EXIT_DELAY   = 3'd2,
    REG_ENTRY_DELAY  = 3'd3,
    REG_SIREN_TICKS  = 3'd4
  } cfg_reg_t;

  localparam logic [3:0] KEY_STAR = 4'd14;
  localparam logic [3:0] KEY_HASH = 4'd15;

  localparam int DEF_MAX_CODE_DIGITS = 8;
  // The secret code holds at most this many nibbles.
  localparam int CODE_NIBBLES = 8;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int DELAY_W     = 20;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 16;

  localparam logic [31:0]        RST_CODE_DIGITS = 32'h0000_0321;
  localparam logic [3:0]         RST_CODE_LENGTH = 4'd3;
  localparam logic [DELAY_W-1:0] RST_DELAY       = 20'd10000;

endpackage

`default_nettype wire

// File: src/intrusion_alarm_controller.sv
// Intrusion alarm controller: key entry buffer, code check, alarm state
// machine and shared delay counter, with a skid-buffered result stream.
// Depends on iac_pkg.
`default_nettype none

// Usage
//   Each transaction on the s_ group is one millisecond tick: key_valid,
//   key_code and motion. Each accepted tick produces exactly one transaction
//   on the m_ group: siren_on, alarm_state, code_accepted, digits_entered.
//   The cfg_ port writes the code, code length and the three delay values;
//   write it only while no tick is in flight.
// Result path and throughput
//   A result goes to the result register, or to the skid register if the
//   output stalls. Key handling, code compare, state and counter update
//   are one logic pass; with s_tready high one tick is taken every cycle.
// Reset
//   rst clears the state to off, the delay counter and the entry buffer,
//   and loads the default registers: code "123", three digits, delay values
//   10000. No clearing pass is needed; ticks are accepted right after reset.
// Stalls
//   A result register and one skid register hold up to two results; while
//   the skid register is full s_tready is low and the state does not move.
module intrusion_alarm_controller #(
  parameter int MAX_CODE_DIGITS = iac_pkg::DEF_MAX_CODE_DIGITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output      logic                           s_tready,
  // [0] key_valid, [4:1] key_code, [5] motion, [7:6] zero
  input  wire logic [iac_pkg::IN_DATA_W-1:0]  s_tdata,
  output      logic                           m_tvalid,
  input  wire logic                           m_tready,
  // [0] siren_on, [3:1] alarm_state, [4] code_accepted, [8:5] digits_entered,
  // [15:9] zero
  output      logic [iac_pkg::OUT_DATA_W-1:0] m_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [iac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [iac_pkg::CFG_DATA_W-1:0] cfg_data
);
  import iac_pkg::*;

  localparam int CNT_W = $clog2(MAX_CODE_DIGITS + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam int NIB   = (MAX_CODE_DIGITS < CODE_NIBBLES) ? MAX_CODE_DIGITS : CODE_NIBBLES;

  // Configuration registers.
  logic [31:0]        code_digits;
  logic [3:0]         code_length;
  logic [DELAY_W-1:0] exit_delay_ticks;
  logic [DELAY_W-1:0] entry_delay_ticks;
  logic [DELAY_W-1:0] siren_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_digits       <= RST_CODE_DIGITS;
      code_length       <= RST_CODE_LENGTH;
      exit_delay_ticks  <= RST_DELAY;
      entry_delay_ticks <= RST_DELAY;
      siren_ticks       <= RST_DELAY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CODE_DIGITS: code_digits       <= cfg_data;
        REG_CODE_LENGTH: code_length       <= cfg_data[3:0];
        REG_EXIT_DELAY:  exit_delay_ticks  <= cfg_data[DELAY_W-1:0];
        REG_ENTRY_DELAY: entry_delay_ticks <= cfg_data[DELAY_W-1:0];
        REG_SIREN_TICKS: siren_ticks       <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Alarm state.
  alarm_state_t                          mode, mode_next;
  logic [DELAY_W-1:0]                    delay_count, delay_count_next;
  logic [MAX_CODE_DIGITS-1:0][3:0]       entry_digits, entry_digits_next;
  logic [CNT_W-1:0]                      entry_count, entry_count_next;

  logic accept_in;
  logic key_valid, motion;
  logic [3:0] key_code;
  logic [CNT_W-1:0] count_key;
  logic match_pre, match_post, expire;
  logic [DELAY_W-1:0] delay_dec;
  logic [OUT_DATA_W-1:0] result;

  // The buffer matches when it holds code_length keys and each one equals
  // the corresponding nibble of the code; only the first eight are compared.
  function automatic logic buf_match(logic [CNT_W-1:0] cnt,
                                     logic [MAX_CODE_DIGITS-1:0][3:0] dig);
    logic ok;
    ok = (CMP_W'(cnt) == CMP_W'(code_length));
    for (int i = 0; i < NIB; i++) begin
      if (cnt > CNT_W'(i) && dig[i] != code_digits[4*i +: 4]) ok = 1'b0;
    end
    return ok;
  endfunction

  assign key_valid = s_tdata[0];
  assign key_code  = s_tdata[4:1];
  assign motion    = s_tdata[5];

  assign expire    = (delay_count <= DELAY_W'(1));
  assign delay_dec = expire ? delay_count : delay_count - DELAY_W'(1);

  always_comb begin
    // Key handling comes first.
    entry_digits_next = entry_digits;
    count_key         = entry_count;
    match_pre         = buf_match(entry_count, entry_digits);
    if (key_valid) begin
      if (key_code == KEY_STAR) begin
        if (match_pre) count_key = '0;
      end else if (key_code == KEY_HASH) begin
        count_key = '0;
      end else if (entry_count < CNT_W'(MAX_CODE_DIGITS)) begin
        for (int i = 0; i < MAX_CODE_DIGITS; i++) begin
          if (entry_count == CNT_W'(i)) entry_digits_next[i] = key_code;
        end
        count_key = entry_count + CNT_W'(1);
      end
    end

    // The post-key check runs in every state; a match empties the buffer.
    match_post       = buf_match(count_key, entry_digits_next);
    entry_count_next = match_post ? '0 : count_key;

    mode_next        = mode;
    delay_count_next = delay_count;
    unique case (mode)
      ST_EXIT: begin
        delay_count_next = delay_dec;
        if (expire) mode_next = ST_ARMED;
        else if (match_post) mode_next = ST_OFF;
      end
      ST_ARMED: begin
        if (match_post) mode_next = ST_OFF;
        else if (motion) mode_next = ST_DETECT;
      end
      ST_DETECT: begin
        delay_count_next = entry_delay_ticks;
        mode_next        = ST_ENTRY;
      end
      ST_ENTRY: begin
        delay_count_next = expire ? siren_ticks : delay_dec;
        if (match_post) mode_next = ST_OFF;
        else if (expire) mode_next = ST_SIREN;
      end
      ST_SIREN: begin
        delay_count_next = expire ? exit_delay_ticks : delay_dec;
        if (expire) mode_next = ST_EXIT;
        else if (match_post) mode_next = ST_OFF;
      end
      default: begin
        if (match_post) begin
          delay_count_next = exit_delay_ticks;
          mode_next        = ST_EXIT;
        end else begin
          mode_next = ST_OFF;
        end
      end
    endcase

    result = {7'b0, 4'(entry_count_next), match_post, mode_next, mode == ST_SIREN};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= ST_OFF;
      delay_count  <= '0;
      entry_digits <= '0;
      entry_count  <= '0;
    end else if (accept_in) begin
      mode         <= mode_next;
      delay_count  <= delay_count_next;
      entry_digits <= entry_digits_next;
      entry_count  <= entry_count_next;
    end
  end

  // Result register with one skid register behind it.
  logic                  out_valid, skid_valid;
  logic [OUT_DATA_W-1:0] out_data, skid_data;

  assign s_tready  = !skid_valid;
  assign accept_in = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept_in;
      end
    end else if (accept_in) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (accept_in) begin
      skid_data <= result;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/alarm_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the intrusion alarm controller: watches the tick, result and
// register write ports, predicts every result and compares it. Uses iac_pkg.
module alarm_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // [0] key_valid, [4:1] key_code, [5] motion, [7:6] zero
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // [0] siren_on, [3:1] alarm_state, [4] code_accepted, [8:5] digits_entered
  input  logic [15:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);
  import iac_pkg::*;

  typedef struct {
    logic       siren_on;
    logic [2:0] alarm_state;
    logic       accepted;
    logic [3:0] digits;
  } alarm_report_t;

  alarm_report_t predicted_reports[$];

  // Register copies.
  logic [31:0]        code_r;
  logic [3:0]         code_len_r;
  logic [DELAY_W-1:0] exit_r;
  logic [DELAY_W-1:0] entry_r;
  logic [DELAY_W-1:0] siren_r;

  // Alarm state copies.
  alarm_state_t       mode_q;
  logic [DELAY_W-1:0] delay_left;
  logic [3:0]         key_buf [DEF_MAX_CODE_DIGITS];
  logic [3:0]         key_count;

  // A match needs the full code length and equal keys; it empties the buffer.
  function automatic logic code_matched();
    logic hit;
    hit = (key_count == code_len_r);
    for (int i = 0; i < DEF_MAX_CODE_DIGITS; i++) begin
      if (i < key_count && key_buf[i] != code_r[4*i +: 4]) hit = 1'b0;
    end
    if (hit) key_count = '0;
    return hit;
  endfunction

  function automatic logic delay_expired();
    if (delay_left <= 1) return 1'b1;
    delay_left = delay_left - 1'b1;
    return 1'b0;
  endfunction

  task automatic advance_alarm(input logic kv, input logic [3:0] kc, input logic mo);
    alarm_report_t rep;
    alarm_state_t  prev;
    alarm_state_t  nxt;
    logic          acc;
    prev = mode_q;
    nxt  = mode_q;
    acc  = 1'b0;
    if (kv) begin
      if (kc == KEY_STAR) begin
        void'(code_matched());
      end else if (kc == KEY_HASH) begin
        key_count = '0;
      end else if (key_count < DEF_MAX_CODE_DIGITS) begin
        key_buf[key_count[2:0]] = kc;
        key_count = key_count + 1'b1;
      end
    end
    case (prev)
      ST_EXIT: begin
        if (code_matched()) begin
          acc = 1'b1;
          nxt = ST_OFF;
        end
        if (delay_expired()) nxt = ST_ARMED;
      end
      ST_ARMED: begin
        if (mo) nxt = ST_DETECT;
        if (code_matched()) begin
          acc = 1'b1;
          nxt = ST_OFF;
        end
      end
      ST_DETECT: begin
        if (code_matched()) acc = 1'b1;
        delay_left = entry_r;
        nxt = ST_ENTRY;
      end
      ST_ENTRY: begin
        if (delay_expired()) begin
          delay_left = siren_r;
          nxt = ST_SIREN;
        end
        if (code_matched()) begin
          acc = 1'b1;
          nxt = ST_OFF;
        end
      end
      ST_SIREN: begin
        if (code_matched()) begin
          acc = 1'b1;
          nxt = ST_OFF;
        end
        if (delay_expired()) begin
          delay_left = exit_r;
          nxt = ST_EXIT;
        end
      end
      default: begin
        if (code_matched()) begin
          acc = 1'b1;
          delay_left = exit_r;
          nxt = ST_EXIT;
        end else begin
          nxt = ST_OFF;
        end
      end
    endcase
    mode_q = nxt;
    rep.siren_on    = (prev == ST_SIREN);
    rep.alarm_state = mode_q;
    rep.accepted    = acc;
    rep.digits      = key_count;
    predicted_reports.push_back(rep);
  endtask

  task automatic check_field(input string name, input logic [3:0] want,
                             input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors = errors + 1;
    end
  endtask

  always @(posedge clk) begin
    alarm_report_t rep;
    if (rst) begin
      code_r     = RST_CODE_DIGITS;
      code_len_r = RST_CODE_LENGTH;
      exit_r     = RST_DELAY;
      entry_r    = RST_DELAY;
      siren_r    = RST_DELAY;
      mode_q     = ST_OFF;
      delay_left = '0;
      key_count  = '0;
      for (int i = 0; i < DEF_MAX_CODE_DIGITS; i++) key_buf[i] = '0;
      predicted_reports.delete();
      errors = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (predicted_reports.size() == 0) begin
          $error("result transaction with no tick pending: m_tdata %h", m_tdata);
          errors = errors + 1;
        end else begin
          rep = predicted_reports.pop_front();
          check_field("siren_on", 4'(rep.siren_on), 4'(m_tdata[0]));
          check_field("alarm_state", 4'(rep.alarm_state), 4'(m_tdata[3:1]));
          check_field("code_accepted", 4'(rep.accepted), 4'(m_tdata[4]));
          check_field("digits_entered", rep.digits, m_tdata[8:5]);
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_CODE_DIGITS: code_r     = cfg_data;
          REG_CODE_LENGTH: code_len_r = cfg_data[3:0];
          REG_EXIT_DELAY:  exit_r     = cfg_data[DELAY_W-1:0];
          REG_ENTRY_DELAY: entry_r    = cfg_data[DELAY_W-1:0];
          REG_SIREN_TICKS: siren_r    = cfg_data[DELAY_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) advance_alarm(s_tdata[0], s_tdata[4:1], s_tdata[5]);
    end
    pending = predicted_reports.size();
  end

endmodule

// File: tb/sv/intrusion_alarm_controller_test.sv
`timescale 1ns / 1ps
// Top of the intrusion alarm controller testbench: clock, reset, tick stimulus,
// register settings and verdict. Depends on iac_pkg and alarm_scoreboard.
module intrusion_alarm_controller_test;
  import iac_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // [0] key_valid, [4:1] key_code, [5] motion, [7:6] zero
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  // [0] siren_on, [3:1] alarm_state, [4] code_accepted, [8:5] digits_entered,
  // [15:9] zero
  logic [15:0] m_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int errors;
  int pending;
  int cycle_count = 0;
  int send_idle_pct;
  int recv_idle_pct;

  // Code currently programmed, used to build well-formed key sequences.
  logic [31:0] cur_code;
  int          cur_len;

  intrusion_alarm_controller dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  alarm_scoreboard sb (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("intrusion_alarm_controller_test: done, errors");
      $finish;
    end
  end

  function automatic logic motion_level();
    return $urandom_range(99) < 12;
  endfunction

  function automatic logic [31:0] enterable_code();
    logic [31:0] c;
    for (int i = 0; i < 8; i++) c[4*i +: 4] = 4'($urandom_range(13));
    return c;
  endfunction

  // One tick transaction; valid stays high from one tick to the next
  // unless the sender idles.
  task automatic send_tick(input logic kv, input logic [3:0] kc, input logic mo);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, mo, kc, kv};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] code, input int len,
                               input int exit_d, input int entry_d, input int siren_d);
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (3) @(negedge clk);
    write_reg(REG_CODE_DIGITS, code);
    write_reg(REG_CODE_LENGTH, 32'(len));
    write_reg(REG_EXIT_DELAY, 32'(exit_d));
    write_reg(REG_ENTRY_DELAY, 32'(entry_d));
    write_reg(REG_SIREN_TICKS, 32'(siren_d));
    cfg_we   <= 1'b0;
    cur_code = code;
    cur_len  = len;
  endtask

  // Mostly code entries (some with a wrong key) and quiet stretches that let
  // the delays run out, with a share of fully random ticks.
  task automatic run_random(input int n);
    int sent;
    int pick;
    int span;
    logic [3:0] k;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(1)) begin
          send_tick(1'b1, KEY_HASH, motion_level());
          sent++;
        end
        for (int i = 0; i < cur_len; i++) begin
          k = cur_code[4*i +: 4];
          if ($urandom_range(99) < 12) k = 4'($urandom_range(13));
          send_tick(1'b1, k, motion_level());
          sent++;
          span = $urandom_range(2);
          repeat (span) send_tick(1'b0, 4'($urandom), motion_level());
          sent += span;
        end
        if ($urandom_range(99) < 10) begin
          send_tick(1'b1, KEY_STAR, motion_level());
          sent++;
        end
      end else if (pick < 75) begin
        span = $urandom_range(40, 1);
        repeat (span) send_tick(1'b0, 4'($urandom), motion_level());
        sent += span;
      end else begin
        send_tick(1'($urandom), 4'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    m_tready      = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 24;
    recv_idle_pct = 82;
    cur_code      = RST_CODE_DIGITS;
    cur_len       = int'(RST_CODE_LENGTH);
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed part with the reset code "123".
    send_tick(1'b0, KEY_HASH, 1'b1);     // key flag low: key ignored
    send_tick(1'b0, 4'd0, 1'b0);
    send_tick(1'b1, 4'd10, 1'b0);        // letters A to D
    send_tick(1'b1, 4'd11, 1'b0);
    send_tick(1'b1, 4'd12, 1'b1);
    send_tick(1'b1, 4'd13, 1'b0);
    send_tick(1'b1, KEY_STAR, 1'b0);     // no match, nothing happens
    send_tick(1'b1, 4'd0, 1'b0);
    send_tick(1'b1, 4'd9, 1'b0);
    send_tick(1'b1, 4'd5, 1'b0);
    send_tick(1'b1, 4'd6, 1'b0);         // buffer now full
    send_tick(1'b1, 4'd7, 1'b0);         // ignored while full
    send_tick(1'b1, KEY_HASH, 1'b0);
    send_tick(1'b1, 4'd1, 1'b0);
    send_tick(1'b1, 4'd2, 1'b0);
    send_tick(1'b1, 4'd3, 1'b0);         // arms through the exit delay
    send_tick(1'b0, 4'd15, 1'b1);
    send_tick(1'b1, 4'd1, 1'b0);
    send_tick(1'b1, 4'd2, 1'b1);
    send_tick(1'b1, 4'd3, 1'b0);         // disarms during the exit delay
    send_tick(1'b1, KEY_HASH, 1'b0);
    send_tick(1'b1, 4'd4, 1'b0);
    send_tick(1'b1, 4'd5, 1'b0);

    // The new code equals the leftover buffer, so the star key empties it
    // without an acceptance.
    apply_setting(32'h0000_0054, 2, 3, 4, 5);
    send_tick(1'b1, KEY_STAR, 1'b0);
    run_random(150);
    apply_setting(32'hFFFF_FFF9, 1, 1, 1, 1);
    run_random(150);

    send_idle_pct = 82;
    recv_idle_pct = 24;
    apply_setting(enterable_code(), 8, $urandom_range(30, 1), $urandom_range(30, 1),
                  $urandom_range(30, 1));
    run_random(150);
    apply_setting(32'h0000_0000, 8, 1048575, 1048575, 1048575);
    run_random(150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_setting(32'hFFFF_FFFF, 3, $urandom_range(20, 1), $urandom_range(20, 1),
                  $urandom_range(20, 1));
    run_random(60);
    apply_setting(enterable_code(), $urandom_range(8, 1), $urandom_range(60, 1),
                  $urandom_range(60, 1), $urandom_range(60, 1));
    run_random(240);

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("intrusion_alarm_controller_test: done, clean");
    end else begin
      $display("intrusion_alarm_controller_test: done, errors");
    end
    $finish;
  end

endmodule

// File: intrusion_alarm_controller.f
src/iac_pkg.sv
src/intrusion_alarm_controller.sv
tb/sv/alarm_scoreboard.sv
tb/sv/intrusion_alarm_controller_test.sv
